@@ rtl/core/rfa_pkg.sv @@
// rfa_pkg: shared types and constants for reduced fraction arithmetic
// no dependencies
package rfa_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int ResultWidth = 32;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic form;
      logic div_start;
      logic div_sel_gcd;
      logic div_sel_num;
      logic div_sel_den;
      logic gcd_shift;
      logic take_num;
      logic take_den;
   } rfa_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rem_zero;
      logic gcd_zero;
   } rfa_sts_type;
endpackage

@@ rtl/core/rfa_ctrl.sv @@
// rfa_ctrl: sequencer for multiply, euclid loop and final divisions
// depends on rfa_pkg
module rfa_ctrl
   import rfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  rfa_sts_type sts,
   output rfa_cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0, S_MA = 4'd1, S_MB = 4'd2, S_FORM = 4'd3,
      S_GSTART = 4'd4, S_GWAIT = 4'd5, S_NSTART = 4'd6, S_NWAIT = 4'd7,
      S_DSTART = 4'd8, S_DWAIT = 4'd9, S_OUT = 4'd10;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MA;
            end
         end
         S_MA: begin
            cmd.mul_a = 1'b1;
            state_in = S_MB;
         end
         S_MB: begin
            cmd.mul_b = 1'b1;
            state_in = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_GSTART;
         end
         S_GSTART: begin
            if (sts.rem_zero) begin
               state_in = sts.gcd_zero ? S_OUT : S_NSTART;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel_gcd = 1'b1;
               state_in = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (sts.div_done) begin
               cmd.gcd_shift = 1'b1;
               state_in = S_GSTART;
            end
         end
         S_NSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_num = 1'b1;
            state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (sts.div_done) begin
               cmd.take_num = 1'b1;
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_den = 1'b1;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               cmd.take_den = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ rtl/core/rfa_div.sv @@
// rfa_div: radix-2 truncating signed divider, one quotient bit per cycle
// depends on rfa_pkg
module rfa_div
   import rfa_pkg::*;
#(
   parameter int W = 2 * OperandWidthDefault + 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] dividend,
   input  logic signed [W-1:0] divisor,
   output logic                done,
   output logic signed [W-1:0] quotient,
   output logic signed [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W-1:0]  rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[W-2:0], quo_ff[W-1]};
      trial   = {1'b0, rem_sh} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend[W-1] ? -dividend : dividend;
         dvs_in  = divisor[W-1] ? -divisor : divisor;
         rem_in  = '0;
         qneg_in = dividend[W-1] ^ divisor[W-1];
         rneg_in = dividend[W-1];
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? -quo_ff : quo_ff;
   assign remainder = rneg_ff ? -rem_ff : rem_ff;
endmodule

@@ rtl/core/rfa_dp.sv @@
// rfa_dp: operand registers, shared multiplier, euclid registers, result registers
// depends on rfa_pkg, rfa_div
module rfa_dp
   import rfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rfa_cmd_type                    cmd,
   output rfa_sts_type                    sts,
   input  logic [1:0]                     req_op,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_b,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_b,
   output logic signed [ResultWidth-1:0]  rsp_res_num,
   output logic signed [ResultWidth-1:0]  rsp_res_den,
   output logic                           rsp_status
);
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int W  = PW + 2;

   logic [1:0]                      op_ff;
   logic signed [OPERAND_WIDTH-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [PW-1:0]            p1_ff, p2_ff, p3_ff, prod;
   logic signed [OPERAND_WIDTH-1:0] mx, my;
   logic signed [W-1:0]             n_ff, m_ff, x_ff, y_ff;
   logic signed [ResultWidth-1:0]   rn_ff, rd_ff;
   logic                            zden_ff;
   logic signed [W-1:0]             dvd, dvs, quo, rem;
   logic                            done;

   // load cycle multiplies the incoming a*d, reused for add, subtract
   always_comb begin
      mx = a_ff;
      my = d_ff;
      if (cmd.load) begin
         mx = req_num_a;
         my = req_den_b;
      end else if (cmd.mul_a) begin
         mx = b_ff;
         my = (op_ff == OP_DIV) ? c_ff : d_ff;
      end else if (!cmd.mul_b) begin
         mx = a_ff;
         my = d_ff;
      end else begin
         unique case (op_ff)
            OP_MUL:  begin mx = a_ff; my = c_ff; end
            OP_DIV:  begin mx = a_ff; my = d_ff; end
            default: begin mx = b_ff; my = c_ff; end
         endcase
      end
   end

   assign prod = PW'(mx * my);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         a_ff <= req_num_a;
         b_ff <= req_den_a;
         c_ff <= req_num_b;
         d_ff <= req_den_b;
         p1_ff <= prod;
      end
      if (cmd.mul_a) p2_ff <= prod;
      if (cmd.mul_b) p3_ff <= prod;
      if (cmd.form) begin
         unique case (op_ff)
            OP_ADD: n_ff <= W'(p1_ff) + W'(p3_ff);
            OP_SUB: n_ff <= W'(p1_ff) - W'(p3_ff);
            OP_MUL: n_ff <= W'(p3_ff);
            default: n_ff <= W'(p3_ff);
         endcase
         m_ff <= W'(p2_ff);
         x_ff <= (op_ff == OP_ADD) ? W'(p1_ff) + W'(p3_ff) :
                 (op_ff == OP_SUB) ? W'(p1_ff) - W'(p3_ff) : W'(p3_ff);
         y_ff <= W'(p2_ff);
         zden_ff <= (p2_ff == '0);
         rn_ff <= '0;
         rd_ff <= '0;
      end
      if (cmd.gcd_shift) begin
         x_ff <= y_ff;
         y_ff <= rem;
      end
      if (cmd.take_num) rn_ff <= ResultWidth'(quo);
      if (cmd.take_den) rd_ff <= ResultWidth'(quo);
   end

   always_comb begin
      dvd = x_ff;
      dvs = y_ff;
      if (cmd.div_sel_num) begin
         dvd = n_ff;
         dvs = x_ff;
      end else if (cmd.div_sel_den) begin
         dvd = m_ff;
         dvs = x_ff;
      end
   end

   rfa_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (done),
      .quotient  (quo),
      .remainder (rem)
   );

   assign sts.div_done = done;
   assign sts.rem_zero = (y_ff == '0);
   assign sts.gcd_zero = (x_ff == '0);

   assign rsp_res_num = rn_ff;
   assign rsp_res_den = rd_ff;
   assign rsp_status  = zden_ff;
endmodule

@@ rtl/core/reduced_fraction_arithmetic.sv @@
// reduced_fraction_arithmetic: top level, one fraction operation per word
// from accept to rsp_valid the radix-2 divider serves each euclid remainder step and both final
// divisions; the final divisions are skipped when the gcd is zero
// one word at a time: req_ready is high only when idle, not again until the result is taken
// synchronous active-high reset returns the sequencer to idle with no result pending
// depends on rfa_pkg, rfa_ctrl, rfa_dp, rfa_div
module reduced_fraction_arithmetic
   import rfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_num_b,
   input  logic signed [OPERAND_WIDTH-1:0] req_den_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [ResultWidth-1:0]   rsp_res_num,
   output logic signed [ResultWidth-1:0]   rsp_res_den,
   output logic                            rsp_status
);
   rfa_cmd_type cmd;
   rfa_sts_type sts;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfa_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_op),
      .req_num_a   (req_num_a),
      .req_den_a   (req_den_a),
      .req_num_b   (req_num_b),
      .req_den_b   (req_den_b),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_one_take: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_num && cmd.take_den)) else $error("double result capture");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_res_num) && $stable(rsp_res_den))
      else $error("result changed while stalled");
endmodule
